### src/assert_macros.svh
// Concurrent assertion wrappers; NO_ASSERTIONS compiles them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### src/mfbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfbp_pkg;

  localparam int JOB_BYTES = 9;
  localparam int WORD_BYTES = 8;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_BITS  = 2'd0,
    FUNC_WORD  = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_t;

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [3:0]                nbytes;
  } job_t;

endpackage

`default_nettype wire

### src/msb_first_bit_packer.sv
// channel  dir  ports                               transfer when
// cfg      in   cfg_valid/ready, cfg_byte_order     cfg_valid & cfg_ready
// in       in   in_valid/ready, func, value, count  in_valid & in_ready
// out      out  out_valid/ready, out_byte, out_last out_valid & out_ready
//
// An item yields 0 to 9 output bytes; one producing no byte pushes no job.
// The output register drains one byte per cycle while out_ready is high, which sets the sustained rate.
// A two-entry job queue lets input transfers continue while the output stalls.
// Synchronous active-low reset clears the pending bits, byte order and queue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module msb_first_bit_packer #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_byte_order,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_value,
  input  logic [5:0]  in_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  import mfbp_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  assign cfg_ready = 1'b1;

  mfbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_byte_order (cfg_byte_order),
    .in_valid       (in_valid),
    .in_func        (in_func),
    .in_value       (in_value),
    .in_count       (in_count),
    .in_ready       (in_ready),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  mfbp_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  mfbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  `ASSERT_ALWAYS(a_out_idle_after_rst, clk, !rst_n |=> !out_valid, "out_valid after reset")
  `ASSERT_RST(a_pop_not_empty, clk, rst_n, pop |-> !q_empty, "pop from empty queue")
  `ASSERT_RST(a_job_rest_queued, clk, rst_n, (out_valid && !out_last) |-> !q_empty, "job tail lost")

endmodule

`default_nettype wire

### src/mfbp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mfbp_front #(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic          cfg_byte_order,
  input  logic          in_valid,
  input  logic [1:0]    in_func,
  input  logic [63:0]   in_value,
  input  logic [5:0]    in_count,
  output logic          in_ready,
  input  logic          q_full,
  output logic          push,
  output mfbp_pkg::job_t push_job
);
  import mfbp_pkg::*;

  localparam int CW   = MAX_FIELD_BITS + 7;
  localparam int LW   = ((CW + 7) / 8) * 8;
  localparam int TW   = $clog2(CW + 1);
  localparam int NW   = ((TW > 6) ? TW : 6) + 1;

  logic          byte_order_r;
  logic [6:0]    partial_r, partial_nxt;
  logic [2:0]    pcnt_r, pcnt_nxt;

  logic          accept;
  logic [TW-1:0] c;
  logic [TW-1:0] total;
  logic [TW:0]   shamt;
  logic [CW-1:0] val_m;
  logic [CW-1:0] combined;
  logic [LW-1:0] aligned;
  logic [2:0]    newpc;
  logic [JOB_BYTES-1:0][7:0] bit_bytes;

  logic          pad;
  logic [7:0]    pad_byte;
  logic [3:0]    nb;
  logic [JOB_BYTES-1:0][7:0] word_bytes;

  job_t          job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Bit write: append field below pending bits, then left align whole bytes.
  assign c = (NW'(in_count) > NW'(MAX_FIELD_BITS)) ? TW'(MAX_FIELD_BITS) : TW'(in_count);
  assign total    = TW'(pcnt_r) + c;
  assign val_m    = CW'(in_value[MAX_FIELD_BITS-1:0]) & ~({CW{1'b1}} << c);
  assign combined = (CW'(partial_r) << c) | val_m;
  assign shamt    = (TW + 1)'(LW) - (TW + 1)'(total);
  assign aligned  = LW'(combined) << shamt;
  assign newpc    = total[2:0];

  genvar k;
  for (k = 0; k < JOB_BYTES; k++) begin : g_bb
    if (k < LW / 8) begin : g_on
      assign bit_bytes[k] = aligned[LW-1-8*k -: 8];
    end else begin : g_off
      assign bit_bytes[k] = 8'h00;
    end
  end

  // Word write and flush: zero padded partial byte first.
  assign pad      = (pcnt_r != 3'd0);
  assign pad_byte = 8'({1'b0, partial_r}) << (4'd8 - {1'b0, pcnt_r});
  assign nb       = (in_count > 6'(WORD_BYTES)) ? 4'(WORD_BYTES) : in_count[3:0];

  always_comb begin
    logic [3:0] idx;
    logic [3:0] sel;
    for (int j = 0; j < JOB_BYTES; j++) begin
      idx = 4'(j) - {3'b000, pad};
      sel = byte_order_r ? (nb - 4'd1 - idx) : idx;
      if (pad && (j == 0)) begin
        word_bytes[j] = pad_byte;
      end else begin
        word_bytes[j] = in_value[sel[2:0]*8 +: 8];
      end
    end
  end

  always_comb begin
    job.bytes   = word_bytes;
    job.nbytes  = 4'd0;
    partial_nxt = partial_r;
    pcnt_nxt    = pcnt_r;
    unique case (func_t'(in_func))
      FUNC_BITS: begin
        job.bytes   = bit_bytes;
        job.nbytes  = 4'(total >> 3);
        partial_nxt = combined[6:0] & ~(7'h7f << newpc);
        pcnt_nxt    = newpc;
      end
      FUNC_WORD: begin
        job.nbytes  = nb + {3'b000, pad};
        partial_nxt = 7'h00;
        pcnt_nxt    = 3'd0;
      end
      FUNC_FLUSH: begin
        job.nbytes  = {3'b000, pad};
        partial_nxt = 7'h00;
        pcnt_nxt    = 3'd0;
      end
      default: begin
        job.nbytes = 4'd0;
      end
    endcase
  end

  assign push     = accept && (job.nbytes != 4'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r <= 1'b0;
      partial_r    <= 7'h00;
      pcnt_r       <= 3'd0;
    end else begin
      if (cfg_valid) begin
        byte_order_r <= cfg_byte_order;
      end
      if (accept) begin
        partial_r <= partial_nxt;
        pcnt_r    <= pcnt_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### src/mfbp_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module mfbp_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mfbp_pkg::job_t push_job,
  input  logic           pop,
  output mfbp_pkg::job_t head_job,
  output logic           full,
  output logic           empty
);
  import mfbp_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  job_t            mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     cnt_r;

  assign full     = (cnt_r == (PW + 1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW + 1)'(push) - (PW + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

### src/mfbp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mfbp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mfbp_pkg::job_t head_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last
);
  import mfbp_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;
  logic       is_last;

  assign load    = !q_empty && (!valid_r || out_ready);
  assign is_last = ((idx_r + 4'd1) == head_job.nbytes);
  assign pop     = load && is_last;
  assign idx_nxt = is_last ? 4'd0 : idx_r + 4'd1;

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head_job.bytes[idx_r];
      last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 4'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
